@@ rtl/dnm_pkg.sv @@
// ----------------------------------------------------------------------------
// dnm_pkg
// Shared types, codes and constants of the descriptor nearest-match block.
// ----------------------------------------------------------------------------
`default_nettype none

package dnm_pkg;

  // default sizing of the reference store
  localparam int unsigned MAX_REFS_DEF = 1024;
  localparam int unsigned MAX_LEN_DEF  = 128;

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned LEN_IN_W = 8;
  localparam int unsigned ELEM_W   = 8;
  localparam int unsigned QIDX_W   = 16;
  localparam int unsigned RIDX_W   = 10;
  localparam int unsigned DIST_W   = 30;
  localparam int unsigned RATIO_W  = 7;
  localparam int unsigned SQ_W     = 2 * ELEM_W;
  localparam int unsigned RSQ_W    = 2 * RATIO_W;
  localparam int unsigned PROD_W   = DIST_W + RSQ_W;

  localparam logic [DIST_W-1:0]  DIST_INIT   = DIST_W'(1000000000);
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(5);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_REF   = 2'd1,
    OP_QUERY = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_META,
    ST_CHECK,
    ST_ELEM,
    ST_DRAIN,
    ST_SQUARE,
    ST_MUL,
    ST_TEST,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [KIND_W-1:0]   desc_type;
    logic [LEN_IN_W-1:0] desc_length;
    logic [ELEM_W-1:0]   element;
  } in_item_t;

  typedef struct packed {
    logic [QIDX_W-1:0] query_index;
    logic [RIDX_W-1:0] ref_index;
    logic [DIST_W-1:0] best_dist;
    logic [DIST_W-1:0] second_dist;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } dist_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/dnm_ram.sv @@
// ----------------------------------------------------------------------------
// dnm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dnm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/dnm_dist.sv @@
// ----------------------------------------------------------------------------
// dnm_dist
// Squared-distance datapath: element difference, square, accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module dnm_dist (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dnm_pkg::dist_ctrl_t               ctrl_i,
  input  wire logic [dnm_pkg::ELEM_W-1:0]        q_elem_i,
  input  wire logic [dnm_pkg::ELEM_W-1:0]        r_elem_i,
  output logic      [dnm_pkg::DIST_W-1:0]        acc_o,
  output logic                                   busy_o
);

  logic                        rd_v_q;
  logic                        sq_v_q;
  logic [dnm_pkg::ELEM_W-1:0]  abs_diff;
  logic [dnm_pkg::SQ_W-1:0]    sq_d;
  logic [dnm_pkg::SQ_W-1:0]    sq_q;
  logic [dnm_pkg::DIST_W-1:0]  acc_d;
  logic [dnm_pkg::DIST_W-1:0]  acc_q;

  // read data arrives in the cycle after the addresses were issued
  always_comb begin
    abs_diff = (q_elem_i >= r_elem_i) ? (q_elem_i - r_elem_i) : (r_elem_i - q_elem_i);
    sq_d     = dnm_pkg::SQ_W'(abs_diff) * dnm_pkg::SQ_W'(abs_diff);
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (sq_v_q) begin
      acc_d = acc_q + dnm_pkg::DIST_W'(sq_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      sq_v_q <= 1'b0;
    end else begin
      rd_v_q <= ctrl_i.issue;
      sq_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      sq_q <= sq_d;
    end
    acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = rd_v_q | sq_v_q;

endmodule

`default_nettype wire

@@ rtl/descriptor_nearest_match_ratio_test.sv @@
// ----------------------------------------------------------------------------
// descriptor_nearest_match_ratio_test
// Nearest-neighbor descriptor matcher with a ratio test over a RAM store.
// ----------------------------------------------------------------------------
// Reference and query descriptors arrive one element per transaction. An
// element that does not end a query leaves the block ready for the next one.
// The last element of a query starts a scan of the stored references, during
// which no input is taken: ST_META and ST_CHECK check each stored reference's
// kind and length; a reference that matches is read in ST_ELEM, the element
// RAM delivering one element per cycle, and summed up in ST_DRAIN. The scan
// ends in ST_META; ST_SQUARE, ST_MUL and ST_TEST run the ratio test, and
// ST_RESULT hands the result off, waiting while an earlier result is still
// held at the output. There is no clearing pass after reset.
`default_nettype none

module descriptor_nearest_match_ratio_test #(
  parameter int unsigned MAX_REFS = dnm_pkg::MAX_REFS_DEF,
  parameter int unsigned MAX_LEN  = dnm_pkg::MAX_LEN_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dnm_pkg::RATIO_W-1:0]   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire dnm_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output dnm_pkg::out_item_t                 out_data_o
);

  localparam int unsigned REF_W   = $clog2(MAX_REFS);
  localparam int unsigned CNT_W   = REF_W + 1;
  localparam int unsigned LEN_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned META_W  = dnm_pkg::KIND_W + LEN_W;
  localparam int unsigned EADDR_W = REF_W + LEN_W;
  localparam logic [CNT_W-1:0]              REFS_MAX   = CNT_W'(MAX_REFS);
  localparam logic [dnm_pkg::LEN_IN_W:0]    LEN_LIMIT  = (dnm_pkg::LEN_IN_W + 1)'(MAX_LEN);
  localparam logic [LEN_W-1:0]              LEN_M1_MAX = LEN_W'(MAX_LEN - 1);

  dnm_pkg::state_e state_q, state_d;

  logic [dnm_pkg::RATIO_W-1:0] ratio_q, ratio_d;
  logic [CNT_W-1:0]            ref_count_q, ref_count_d;
  logic [LEN_W-1:0]            elem_cnt_q, elem_cnt_d;
  logic                        building_q, building_d;
  logic [dnm_pkg::KIND_W-1:0]  ckind_q, ckind_d;
  logic [LEN_W-1:0]            clen_m1_q, clen_m1_d;
  logic [dnm_pkg::QIDX_W-1:0]  query_cnt_q, query_cnt_d;
  logic [dnm_pkg::QIDX_W-1:0]  qn_q, qn_d;
  logic [CNT_W-1:0]            k_q, k_d;
  logic [LEN_W-1:0]            i_q, i_d;
  logic [dnm_pkg::DIST_W-1:0]  best_q, best_d;
  logic [dnm_pkg::DIST_W-1:0]  second_q, second_d;
  logic [REF_W-1:0]            best_idx_q, best_idx_d;
  logic                        found_q, found_d;
  logic [dnm_pkg::RSQ_W-1:0]   b2_q, b2_d;
  logic [dnm_pkg::RSQ_W-1:0]   bm2_q, bm2_d;
  logic [dnm_pkg::PROD_W-1:0]  lhs_q, lhs_d;
  logic [dnm_pkg::PROD_W-1:0]  rhs_q, rhs_d;
  logic                        out_valid_q, out_valid_d;
  dnm_pkg::out_item_t          out_data_q, out_data_d;

  // input decode
  logic                        in_acc;
  logic                        is_clr;
  logic                        is_ref;
  logic                        is_qry;
  logic                        new_desc;
  logic [LEN_W-1:0]            elen_m1;
  logic [dnm_pkg::KIND_W-1:0]  cur_kind;
  logic [LEN_W-1:0]            cur_m1;
  logic [LEN_W-1:0]            idx;
  logic                        last;
  logic                        store_ok;
  logic [dnm_pkg::RATIO_W-1:0] bm1;

  // memory and datapath control
  logic                        elem_we;
  logic                        meta_we;
  logic                        qry_we;
  logic                        meta_re;
  logic                        elem_re;
  logic [META_W-1:0]           meta_rdata;
  logic                        meta_hit;
  logic [dnm_pkg::ELEM_W-1:0]  q_rdata;
  logic [dnm_pkg::ELEM_W-1:0]  r_rdata;
  dnm_pkg::dist_ctrl_t         dist_ctrl;
  logic [dnm_pkg::DIST_W-1:0]  dist_acc;
  logic                        dist_busy;
  logic                        out_load;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & in_ready_o;

  always_comb begin
    is_clr = 1'b0;
    is_ref = 1'b0;
    is_qry = 1'b0;
    unique case (in_data_i.opcode)
      dnm_pkg::OP_CLEAR: is_clr = 1'b1;
      dnm_pkg::OP_REF:   is_ref = 1'b1;
      dnm_pkg::OP_QUERY: is_qry = 1'b1;
      default:           ;
    endcase
  end

  // length of a new descriptor, clamped to 1..MAX_LEN, kept minus one
  always_comb begin
    if (in_data_i.desc_length == '0) begin
      elen_m1 = '0;
    end else if ({1'b0, in_data_i.desc_length} > LEN_LIMIT) begin
      elen_m1 = LEN_M1_MAX;
    end else begin
      elen_m1 = LEN_W'(in_data_i.desc_length - dnm_pkg::LEN_IN_W'(1));
    end
  end

  // a switch between reference and query drops the partial descriptor
  assign new_desc = (elem_cnt_q == '0) || (building_q != is_qry);
  assign cur_kind = new_desc ? in_data_i.desc_type : ckind_q;
  assign cur_m1   = new_desc ? elen_m1 : clen_m1_q;
  assign idx      = new_desc ? '0 : elem_cnt_q;
  assign last     = (idx == cur_m1);
  assign store_ok = (ref_count_q < REFS_MAX);

  assign elem_we = in_acc & is_ref & store_ok;
  assign meta_we = in_acc & is_ref & store_ok & last;
  assign qry_we  = in_acc & is_qry;

  assign meta_hit = (meta_rdata == {ckind_q, clen_m1_q});
  assign bm1      = (ratio_q == '0) ? dnm_pkg::RATIO_W'(1) : (ratio_q - dnm_pkg::RATIO_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dnm_pkg::ST_IDLE: begin
        if (in_acc && is_qry && last) begin
          state_d = dnm_pkg::ST_META;
        end
      end
      dnm_pkg::ST_META: begin
        if (k_q == ref_count_q) begin
          state_d = found_q ? dnm_pkg::ST_SQUARE : dnm_pkg::ST_IDLE;
        end else begin
          state_d = dnm_pkg::ST_CHECK;
        end
      end
      dnm_pkg::ST_CHECK:  state_d = meta_hit ? dnm_pkg::ST_ELEM : dnm_pkg::ST_META;
      dnm_pkg::ST_ELEM: begin
        if (i_q == clen_m1_q) begin
          state_d = dnm_pkg::ST_DRAIN;
        end
      end
      dnm_pkg::ST_DRAIN: begin
        if (!dist_busy) begin
          state_d = dnm_pkg::ST_META;
        end
      end
      dnm_pkg::ST_SQUARE: state_d = dnm_pkg::ST_MUL;
      dnm_pkg::ST_MUL:    state_d = dnm_pkg::ST_TEST;
      dnm_pkg::ST_TEST:   state_d = (lhs_q < rhs_q) ? dnm_pkg::ST_RESULT : dnm_pkg::ST_IDLE;
      dnm_pkg::ST_RESULT: begin
        if (out_load) begin
          state_d = dnm_pkg::ST_IDLE;
        end
      end
      default:            state_d = dnm_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o      = 1'b0;
    meta_re         = 1'b0;
    elem_re         = 1'b0;
    dist_ctrl.clear = 1'b0;
    dist_ctrl.issue = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      dnm_pkg::ST_IDLE:   in_ready_o = 1'b1;
      dnm_pkg::ST_META:   meta_re    = (k_q != ref_count_q);
      dnm_pkg::ST_CHECK:  dist_ctrl.clear = meta_hit;
      dnm_pkg::ST_ELEM: begin
        elem_re         = 1'b1;
        dist_ctrl.issue = 1'b1;
      end
      dnm_pkg::ST_RESULT: out_load = !out_valid_q || out_ready_i;
      default:            ;
    endcase
  end

  // datapath next values
  always_comb begin
    ratio_d     = ratio_q;
    ref_count_d = ref_count_q;
    elem_cnt_d  = elem_cnt_q;
    building_d  = building_q;
    ckind_d     = ckind_q;
    clen_m1_d   = clen_m1_q;
    query_cnt_d = query_cnt_q;
    qn_d        = qn_q;
    k_d         = k_q;
    i_d         = i_q;
    best_d      = best_q;
    second_d    = second_q;
    best_idx_d  = best_idx_q;
    found_d     = found_q;
    b2_d        = b2_q;
    bm2_d       = bm2_q;
    lhs_d       = lhs_q;
    rhs_d       = rhs_q;
    out_data_d  = out_data_q;

    if (cfg_valid_i) begin
      ratio_d = cfg_data_i;
    end

    unique case (state_q)
      dnm_pkg::ST_IDLE: begin
        if (in_acc && is_clr) begin
          ref_count_d = '0;
          query_cnt_d = '0;
          elem_cnt_d  = '0;
          building_d  = 1'b0;
        end else if (in_acc && (is_ref || is_qry)) begin
          elem_cnt_d = last ? '0 : LEN_W'(idx + 1'b1);
          building_d = is_qry;
          ckind_d    = cur_kind;
          clen_m1_d  = cur_m1;
          if (meta_we) begin
            ref_count_d = ref_count_q + 1'b1;
          end
          if (is_qry && last) begin
            qn_d        = query_cnt_q;
            query_cnt_d = query_cnt_q + 1'b1;
            k_d         = '0;
            best_d      = dnm_pkg::DIST_INIT;
            second_d    = dnm_pkg::DIST_INIT;
            best_idx_d  = '0;
            found_d     = 1'b0;
          end
        end
      end
      dnm_pkg::ST_CHECK: begin
        if (meta_hit) begin
          i_d = '0;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      dnm_pkg::ST_ELEM: i_d = LEN_W'(i_q + 1'b1);
      dnm_pkg::ST_DRAIN: begin
        if (!dist_busy) begin
          // ties keep the earlier reference as best
          if (dist_acc < best_q) begin
            second_d   = best_q;
            best_d     = dist_acc;
            best_idx_d = k_q[REF_W-1:0];
            found_d    = 1'b1;
          end else if (dist_acc < second_q) begin
            second_d = dist_acc;
          end
          k_d = k_q + 1'b1;
        end
      end
      dnm_pkg::ST_SQUARE: begin
        b2_d  = dnm_pkg::RSQ_W'(ratio_q) * dnm_pkg::RSQ_W'(ratio_q);
        bm2_d = dnm_pkg::RSQ_W'(bm1) * dnm_pkg::RSQ_W'(bm1);
      end
      dnm_pkg::ST_MUL: begin
        lhs_d = dnm_pkg::PROD_W'(best_q) * dnm_pkg::PROD_W'(b2_q);
        rhs_d = dnm_pkg::PROD_W'(second_q) * dnm_pkg::PROD_W'(bm2_q);
      end
      dnm_pkg::ST_RESULT: begin
        if (out_load) begin
          out_data_d.query_index = qn_q;
          out_data_d.ref_index   = dnm_pkg::RIDX_W'(best_idx_q);
          out_data_d.best_dist   = best_q;
          out_data_d.second_dist = second_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dnm_pkg::ST_IDLE;
      ratio_q     <= dnm_pkg::RATIO_RESET;
      ref_count_q <= '0;
      elem_cnt_q  <= '0;
      building_q  <= 1'b0;
      query_cnt_q <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ratio_q     <= ratio_d;
      ref_count_q <= ref_count_d;
      elem_cnt_q  <= elem_cnt_d;
      building_q  <= building_d;
      query_cnt_q <= query_cnt_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ckind_q    <= ckind_d;
    clen_m1_q  <= clen_m1_d;
    qn_q       <= qn_d;
    k_q        <= k_d;
    i_q        <= i_d;
    best_q     <= best_d;
    second_q   <= second_d;
    best_idx_q <= best_idx_d;
    b2_q       <= b2_d;
    bm2_q      <= bm2_d;
    lhs_q      <= lhs_d;
    rhs_q      <= rhs_d;
    out_data_q <= out_data_d;
  end

  // reference elements, one row of 2**LEN_W slots per reference
  dnm_ram #(
    .WIDTH (dnm_pkg::ELEM_W),
    .DEPTH (MAX_REFS << LEN_W)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (EADDR_W'({ref_count_q[REF_W-1:0], idx})),
    .wdata_i (in_data_i.element),
    .re_i    (elem_re),
    .raddr_i (EADDR_W'({k_q[REF_W-1:0], i_q})),
    .rdata_o (r_rdata)
  );

  // kind and length minus one of each stored reference
  dnm_ram #(
    .WIDTH (META_W),
    .DEPTH (MAX_REFS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (ref_count_q[REF_W-1:0]),
    .wdata_i ({cur_kind, cur_m1}),
    .re_i    (meta_re),
    .raddr_i (k_q[REF_W-1:0]),
    .rdata_o (meta_rdata)
  );

  dnm_ram #(
    .WIDTH (dnm_pkg::ELEM_W),
    .DEPTH (2 ** LEN_W)
  ) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (qry_we),
    .waddr_i (idx),
    .wdata_i (in_data_i.element),
    .re_i    (elem_re),
    .raddr_i (i_q),
    .rdata_o (q_rdata)
  );

  dnm_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (dist_ctrl),
    .q_elem_i (q_rdata),
    .r_elem_i (r_rdata),
    .acc_o    (dist_acc),
    .busy_o   (dist_busy)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ rtl/dnm_checker.sv @@
// ----------------------------------------------------------------------------
// dnm_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dnm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire dnm_pkg::out_item_t            out_data_o
);

  // a pending result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a result only appears after a scan, when no input was taken
  a_rise_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result raised outside of a scan");

  a_dist_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.best_dist <= out_data_o.second_dist)
    else $error("best distance above second distance");

  // a reported match always has a real best candidate
  a_best_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.best_dist < dnm_pkg::DIST_INIT)
    else $error("result without a candidate");

endmodule

bind descriptor_nearest_match_ratio_test dnm_checker u_dnm_checker (.*);

`default_nettype wire

@@ tb/sv/descriptor_nearest_match_ratio_test_tb.sv @@
// ----------------------------------------------------------------------------
// descriptor_nearest_match_ratio_test_tb
// Self-checking bench for the descriptor nearest-match block: reference and
// query descriptors go in one element per transaction, and a behavioral
// matcher kept here predicts every result, which is then checked field by
// field. It covers directed corner cases, a full reference store, ratio
// settings at their extremes, a long output stall and random traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module descriptor_nearest_match_ratio_test_tb;

  // small store so that it fills up within a short run
  localparam int MAX_REFS    = 32;
  localparam int MAX_LEN     = dnm_pkg::MAX_LEN_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [dnm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [dnm_pkg::RATIO_W-1:0] cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  dnm_pkg::in_item_t           in_data = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  dnm_pkg::out_item_t          out_data;

  // matcher state mirrored on the bench side
  logic [dnm_pkg::ELEM_W-1:0]  ref_store [MAX_REFS][MAX_LEN];
  logic [dnm_pkg::KIND_W-1:0]  ref_kind_tab [MAX_REFS];
  int                          ref_len_tab [MAX_REFS];
  int                          stored_refs = 0;
  logic [dnm_pkg::ELEM_W-1:0]  query_buf [MAX_LEN];
  int                          elem_pos = 0;
  logic [dnm_pkg::KIND_W-1:0]  cur_kind = '0;
  int                          cur_len = 1;
  logic                        in_query = 1'b0;
  logic [dnm_pkg::QIDX_W-1:0]  query_count = '0;
  logic [dnm_pkg::RATIO_W-1:0] ratio_b = dnm_pkg::RATIO_RESET;
  int                          scan_cycles = 4;

  dnm_pkg::out_item_t          expected_matches [$];
  dnm_pkg::out_item_t          want;
  logic [dnm_pkg::ELEM_W-1:0]  desc_buf [MAX_LEN];
  int                          ratio_edges [5] = '{0, 1, 2, 64, 127};

  int tx_idle_pct = 37;
  int rx_idle_pct = 52;
  int rx_hold = 0;
  int stim_items = 0;
  int results_seen = 0;
  int silent_queries = 0;
  int errors = 0;
  int cycle_count = 0;

  descriptor_nearest_match_ratio_test #(
    .MAX_REFS (MAX_REFS),
    .MAX_LEN  (MAX_LEN)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_matches.size());
      $display("descriptor_nearest_match_ratio_test_tb NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = expected_matches.pop_front();
        results_seen++;
        if (out_data.query_index != want.query_index) begin
          $display("%0t: query_index: expected %0d, actual %0d", $time,
                   want.query_index, out_data.query_index);
          errors++;
        end
        if (out_data.ref_index != want.ref_index) begin
          $display("%0t: ref_index: expected %0d, actual %0d", $time,
                   want.ref_index, out_data.ref_index);
          errors++;
        end
        if (out_data.best_dist != want.best_dist) begin
          $display("%0t: best_dist: expected %0d, actual %0d", $time,
                   want.best_dist, out_data.best_dist);
          errors++;
        end
        if (out_data.second_dist != want.second_dist) begin
          $display("%0t: second_dist: expected %0d, actual %0d", $time,
                   want.second_dist, out_data.second_dist);
          errors++;
        end
      end
    end
  end

  function automatic int effective_len(input logic [dnm_pkg::LEN_IN_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_LEN) return MAX_LEN;
    return int'(raw);
  endfunction

  // one accepted transaction through the matcher; pushes the match it yields
  function automatic void predict_match(input dnm_pkg::in_item_t item);
    logic                       is_query;
    int unsigned                best, second, sq_sum, best_idx, candidates;
    int                         qv, rv, diff;
    logic [dnm_pkg::QIDX_W-1:0] this_query;
    longint unsigned            b, bm1;
    logic                       found;
    dnm_pkg::out_item_t         exp_item;
    scan_cycles = 4;
    if (item.opcode == dnm_pkg::OP_CLEAR) begin
      stored_refs = 0;
      query_count = '0;
      elem_pos = 0;
      in_query = 1'b0;
      return;
    end
    if (item.opcode == OP_UNUSED) return;
    is_query = (item.opcode == dnm_pkg::OP_QUERY);
    // first element, or opcode switch dropping a partial descriptor
    if (elem_pos == 0 || in_query != is_query) begin
      elem_pos = 0;
      in_query = is_query;
      cur_kind = item.desc_type;
      cur_len = effective_len(item.desc_length);
    end
    if (is_query) begin
      query_buf[elem_pos] = item.element;
    end else if (stored_refs < MAX_REFS) begin
      ref_store[stored_refs][elem_pos] = item.element;
    end
    elem_pos++;
    if (elem_pos < cur_len) return;
    elem_pos = 0;
    if (!is_query) begin
      // full store: descriptor consumed and dropped
      if (stored_refs < MAX_REFS) begin
        ref_kind_tab[stored_refs] = cur_kind;
        ref_len_tab[stored_refs] = cur_len;
        stored_refs++;
      end
      return;
    end
    this_query = query_count;
    query_count = query_count + 1'b1;
    best = dnm_pkg::DIST_INIT;
    second = dnm_pkg::DIST_INIT;
    best_idx = 0;
    found = 1'b0;
    candidates = 0;
    for (int k = 0; k < stored_refs; k++) begin
      if (ref_kind_tab[k] == cur_kind && ref_len_tab[k] == cur_len) begin
        candidates++;
        sq_sum = 0;
        for (int i = 0; i < cur_len; i++) begin
          qv = query_buf[i];
          rv = ref_store[k][i];
          diff = qv - rv;
          sq_sum += diff * diff;
        end
        if (sq_sum < best) begin
          second = best;
          best = sq_sum;
          best_idx = k;
          found = 1'b1;
        end else if (sq_sum < second) begin
          second = sq_sum;
        end
      end
    end
    scan_cycles = 2 * stored_refs + candidates * (cur_len + 5) + 8;
    b = ratio_b;
    bm1 = (ratio_b >= 1) ? b - 1 : 1;
    if (found && longint'(best) * b * b < longint'(second) * bm1 * bm1) begin
      exp_item.query_index = this_query;
      exp_item.ref_index = dnm_pkg::RIDX_W'(best_idx);
      exp_item.best_dist = dnm_pkg::DIST_W'(best);
      exp_item.second_dist = dnm_pkg::DIST_W'(second);
      expected_matches.push_back(exp_item);
    end else begin
      silent_queries++;
    end
  endfunction

  task automatic send_item(input dnm_pkg::in_item_t item);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_match(item);
    stim_items++;
  endtask

  task automatic send_element(input logic [dnm_pkg::OP_W-1:0] op,
                              input logic [dnm_pkg::KIND_W-1:0] kind,
                              input logic [dnm_pkg::LEN_IN_W-1:0] len,
                              input logic [dnm_pkg::ELEM_W-1:0] value);
    dnm_pkg::in_item_t item;
    item.opcode = op;
    item.desc_type = kind;
    item.desc_length = len;
    item.element = value;
    send_item(item);
  endtask

  // sends desc_buf; ragged adds unused-opcode noise and may cut the descriptor short
  task automatic send_descriptor(input logic [dnm_pkg::OP_W-1:0] op,
                                 input logic [dnm_pkg::KIND_W-1:0] kind,
                                 input logic [dnm_pkg::LEN_IN_W-1:0] raw_len, input bit ragged);
    int count;
    count = effective_len(raw_len);
    if (ragged && count > 1 && $urandom_range(99) < 5) count = $urandom_range(1, count - 1);
    for (int i = 0; i < count; i++) begin
      if (ragged && $urandom_range(99) < 4) begin
        send_element(OP_UNUSED, dnm_pkg::KIND_W'($urandom_range(15)),
                     dnm_pkg::LEN_IN_W'($urandom_range(255)),
                     dnm_pkg::ELEM_W'($urandom_range(255)));
      end
      // type and length past the first element are ignored by the block
      if (i == 0) send_element(op, kind, raw_len, desc_buf[i]);
      else send_element(op, dnm_pkg::KIND_W'($urandom_range(15)),
                        dnm_pkg::LEN_IN_W'($urandom_range(255)), desc_buf[i]);
    end
  endtask

  function automatic void fill_random(input int len);
    for (int i = 0; i < len; i++) desc_buf[i] = dnm_pkg::ELEM_W'($urandom_range(255));
  endfunction

  function automatic void copy_ref(input int idx, input int jitter);
    int pos;
    for (int i = 0; i < ref_len_tab[idx]; i++) desc_buf[i] = ref_store[idx][i];
    repeat (jitter) begin
      pos = $urandom_range(ref_len_tab[idx] - 1);
      desc_buf[pos] = desc_buf[pos] + dnm_pkg::ELEM_W'($urandom_range(1, 4));
    end
  endfunction

  // length field: zero stands for one, anything above the max for the max
  function automatic logic [dnm_pkg::LEN_IN_W-1:0] raw_length(input int len);
    if (len == 1 && $urandom_range(1) == 1) return '0;
    if (len == MAX_LEN && $urandom_range(1) == 1) begin
      return dnm_pkg::LEN_IN_W'($urandom_range(MAX_LEN + 1, 255));
    end
    return dnm_pkg::LEN_IN_W'(len);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 24);
    if (r < 97) return $urandom_range(100, MAX_LEN - 1);
    return MAX_LEN;
  endfunction

  // idle input, every result in, then time for a scan that yields nothing
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (scan_cycles + 16) @(posedge clk);
  endtask

  task automatic write_ratio_bound(input logic [dnm_pkg::RATIO_W-1:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ratio_b = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_element(dnm_pkg::OP_REF, 3, 2, 0);
    send_element(dnm_pkg::OP_REF, 3, 2, 255);
    send_element(dnm_pkg::OP_REF, 3, 2, 255);
    send_element(dnm_pkg::OP_REF, 3, 2, 0);
    send_element(dnm_pkg::OP_REF, 3, 0, 7);         // zero length means one element
    send_element(dnm_pkg::OP_QUERY, 3, 2, 0);
    send_element(dnm_pkg::OP_QUERY, 3, 2, 255);
    send_element(dnm_pkg::OP_QUERY, 3, 0, 7);
    send_element(dnm_pkg::OP_QUERY, 15, 2, 1);      // no reference of that kind
    send_element(dnm_pkg::OP_QUERY, 15, 2, 2);
    send_element(dnm_pkg::OP_QUERY, 3, 2, 128);
    send_element(OP_UNUSED, 15, 255, 255);          // ignored mid-descriptor
    send_element(dnm_pkg::OP_QUERY, 3, 2, 127);     // close runner-up, ratio rejects
    send_element(dnm_pkg::OP_REF, 5, 4, 1);
    send_element(dnm_pkg::OP_REF, 5, 4, 2);
    send_element(dnm_pkg::OP_QUERY, 3, 1, 7);       // opcode switch drops partial ref
    send_element(dnm_pkg::OP_QUERY, 3, 2, 0);
    send_element(dnm_pkg::OP_REF, 0, 1, 200);       // and the other way round
    send_element(dnm_pkg::OP_QUERY, 3, 2, 0);
    send_element(dnm_pkg::OP_CLEAR, 0, 0, 0);       // clear mid-query
    send_element(dnm_pkg::OP_QUERY, 3, 1, 7);       // empty store
    send_element(dnm_pkg::OP_REF, 3, 1, 7);
    send_element(dnm_pkg::OP_QUERY, 3, 1, 7);
    wait_for_idle();
  endtask

  task automatic test_store_full();
    send_element(dnm_pkg::OP_CLEAR, 0, 0, 0);
    for (int i = 0; i < MAX_REFS; i++) begin
      send_element(dnm_pkg::OP_REF, dnm_pkg::KIND_W'($urandom_range(14)), 1,
                   dnm_pkg::ELEM_W'($urandom_range(255)));
    end
    // no room left: these are consumed and dropped
    repeat (4) send_element(dnm_pkg::OP_REF, 15, 1, 42);
    fill_random(3);
    send_descriptor(dnm_pkg::OP_REF, 15, 3, 1'b0);
    send_element(dnm_pkg::OP_QUERY, 15, 1, 42);
    repeat (6) begin
      send_element(dnm_pkg::OP_QUERY, dnm_pkg::KIND_W'($urandom_range(14)),
                   dnm_pkg::LEN_IN_W'($urandom_range(1)),
                   dnm_pkg::ELEM_W'($urandom_range(255)));
    end
    wait_for_idle();
  endtask

  task automatic test_ratio_extremes();
    for (int e = 0; e < 5; e++) begin
      wait_for_idle();
      write_ratio_bound(dnm_pkg::RATIO_W'(ratio_edges[e]));
      send_element(dnm_pkg::OP_CLEAR, 0, 0, 0);
      repeat (3) begin
        fill_random(2);
        send_descriptor(dnm_pkg::OP_REF, 6, 2, 1'b0);
      end
      copy_ref(0, 1);
      send_descriptor(dnm_pkg::OP_REF, 6, 2, 1'b0);
      for (int q = 0; q < 4; q++) begin
        copy_ref($urandom_range(3), q % 2);
        send_descriptor(dnm_pkg::OP_QUERY, 6, 2, 1'b0);
      end
    end
    wait_for_idle();
  endtask

  task automatic test_output_backpressure();
    write_ratio_bound(6);
    send_element(dnm_pkg::OP_CLEAR, 0, 0, 0);
    for (int r = 0; r < 4; r++) begin
      fill_random(3);
      send_descriptor(dnm_pkg::OP_REF, 10, 3, 1'b0);
    end
    // long receiver stall while queries keep coming
    rx_hold = 400;
    for (int q = 0; q < 8; q++) begin
      copy_ref(q % 4, 0);
      send_descriptor(dnm_pkg::OP_QUERY, 10, 3, 1'b0);
    end
    wait_for_idle();
    // full-length descriptors given with an oversized length field
    fill_random(MAX_LEN);
    send_descriptor(dnm_pkg::OP_REF, 12, 200, 1'b0);
    copy_ref(4, 1);
    send_descriptor(dnm_pkg::OP_QUERY, 12, 255, 1'b0);
    wait_for_idle();
  endtask

  task automatic random_round();
    int n_refs, n_queries, len_a, len_b, len, j, pick;
    logic [dnm_pkg::KIND_W-1:0] kind_a, kind_b, kind;
    wait_for_idle();
    if ($urandom_range(1) == 1) begin
      if ($urandom_range(2) == 0) begin
        write_ratio_bound(dnm_pkg::RATIO_W'(ratio_edges[$urandom_range(4)]));
      end else begin
        write_ratio_bound(dnm_pkg::RATIO_W'($urandom_range(2, 12)));
      end
    end
    send_element(dnm_pkg::OP_CLEAR, dnm_pkg::KIND_W'($urandom_range(15)),
                 dnm_pkg::LEN_IN_W'($urandom_range(255)), dnm_pkg::ELEM_W'($urandom_range(255)));
    kind_a = dnm_pkg::KIND_W'($urandom_range(15));
    kind_b = dnm_pkg::KIND_W'($urandom_range(15));
    len_a = pick_len();
    len_b = pick_len();
    n_refs = $urandom_range(1, 12);
    for (int r = 0; r < n_refs; r++) begin
      if (stored_refs != 0 && $urandom_range(9) < 3) begin
        // near twin of an earlier reference, to make close runner-ups
        j = $urandom_range(stored_refs - 1);
        copy_ref(j, $urandom_range(0, 2));
        kind = ref_kind_tab[j];
        len = ref_len_tab[j];
      end else begin
        kind = $urandom_range(1) ? kind_a : kind_b;
        len = $urandom_range(1) ? len_a : len_b;
        fill_random(len);
      end
      send_descriptor(dnm_pkg::OP_REF, kind, raw_length(len), 1'b1);
    end
    n_queries = $urandom_range(2, 8);
    for (int q = 0; q < n_queries; q++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_element(dnm_pkg::OP_CLEAR, dnm_pkg::KIND_W'($urandom_range(15)),
                     dnm_pkg::LEN_IN_W'($urandom_range(255)),
                     dnm_pkg::ELEM_W'($urandom_range(255)));
      end
      if (stored_refs != 0 && pick < 80) begin
        j = $urandom_range(stored_refs - 1);
        copy_ref(j, (pick < 40) ? $urandom_range(1, 3) : 0);
        kind = ref_kind_tab[j];
        len = ref_len_tab[j];
      end else begin
        kind = (pick < 90) ? kind_a : dnm_pkg::KIND_W'($urandom_range(15));
        len = (pick < 90) ? len_a : pick_len();
        fill_random(len);
      end
      send_descriptor(dnm_pkg::OP_QUERY, kind, raw_length(len), 1'b1);
    end
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
    int start;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = stim_items;
    while (stim_items - start < n_items) random_round();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_store_full();
    test_ratio_extremes();
    test_output_backpressure();
    test_random_traffic(37, 52, 35);
    test_random_traffic(52, 37, 35);
    test_random_traffic(0, 0, 30);
    wait_for_idle();
    $display("run covered %0d element transactions: corner cases, full store, ratio 0..127,",
             stim_items);
    $display("long output stall, random traffic; %0d matches checked, %0d queries unmatched",
             results_seen, silent_queries);
    if (errors == 0) begin
      $display("descriptor_nearest_match_ratio_test_tb OK");
    end else begin
      $display("descriptor_nearest_match_ratio_test_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/dnm_pkg.sv
rtl/dnm_ram.sv
rtl/dnm_dist.sv
rtl/descriptor_nearest_match_ratio_test.sv
rtl/dnm_checker.sv
tb/sv/descriptor_nearest_match_ratio_test_tb.sv
